>>> sv/lss_pkg.sv
// shared constants and controller/datapath interface types
`default_nettype none
package lss_pkg;

	localparam int DEPTH   = 1024;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = 43;
	localparam int ELEM_W  = 32;
	localparam int LEN_W   = 11;
	localparam int POS_W   = 10;
	localparam int ENTRY_W = SUM_W + IDX_W;

	typedef struct packed {
		logic take;
		logic check;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic table_empty;
		logic scan_end;
	} sts_t;

endpackage
`default_nettype wire

>>> sv/lss_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module lss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> sv/lss_ctrl.sv
// controller state machine: take, prefix check, table scan, drain, finish
`default_nettype none
module lss_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire lss_pkg::sts_t sts,
	output lss_pkg::cmd_t      cmd,
	output logic               busy
);
	import lss_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.take = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.active) begin
					state_d = ST_FINISH;
				end else begin
					cmd.check = 1'b1;
					state_d   = sts.table_empty ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			// last read data is compared here
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

`ifndef SYNTHESIS
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !sts.table_empty)
		else $error("table scan with empty table");
`endif

endmodule
`default_nettype wire

>>> sv/lss_datapath.sv
// datapath: prefix sum, prefix table ram, best-subarray tracking, result registers
`default_nettype none
module lss_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               target_sum_we,
	input  wire logic signed [lss_pkg::SUM_W-1:0]   target_sum,
	input  wire logic signed [lss_pkg::ELEM_W-1:0]  element,
	input  wire logic                               last,
	input  wire lss_pkg::cmd_t                      cmd,
	output lss_pkg::sts_t                           sts,
	output logic                                    done,
	output logic             [lss_pkg::LEN_W-1:0]   best_length,
	output logic                                    found,
	output logic             [lss_pkg::POS_W-1:0]   start_pos,
	output logic             [lss_pkg::POS_W-1:0]   end_pos,
	output logic                                    overflow
);
	import lss_pkg::*;

	logic [SUM_W-1:0]   target_q;
	logic [SUM_W-1:0]   running_q;
	logic [SUM_W-1:0]   diff_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   position_q;
	logic [CNT_W-1:0]   best_len_q;
	logic [IDX_W-1:0]   best_start_q;
	logic [IDX_W-1:0]   best_end_q;
	logic               ovf_q;
	logic               active_q;
	logic               last_q;
	logic               present_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic               valid_s1;
	logic               done_q;

	logic [ENTRY_W-1:0] rd_data;
	logic [SUM_W-1:0]   rd_sum;
	logic [IDX_W-1:0]   rd_pos;
	logic [CNT_W-1:0]   cand_len;
	logic               hit_diff;
	logic               hit_same;
	logic [SUM_W-1:0]   sum_next;
	logic               room;
	logic               wr_en;

	assign rd_sum   = rd_data[ENTRY_W-1:IDX_W];
	assign rd_pos   = rd_data[IDX_W-1:0];
	assign cand_len = position_q - CNT_W'(rd_pos);
	assign hit_diff = valid_s1 && (rd_sum == diff_q);
	assign hit_same = valid_s1 && (rd_sum == running_q);
	assign sum_next = running_q + {{(SUM_W - ELEM_W){element[ELEM_W-1]}}, element};
	assign room     = (position_q < CNT_W'(DEPTH));
	// new prefix goes in only if no stored entry matched it
	assign wr_en    = cmd.finish && active_q && !last_q && !present_q
		&& (count_q < CNT_W'(DEPTH));

	lss_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data ({running_q, position_q[IDX_W-1:0]}),
		.rd_en   (cmd.scan),
		.rd_addr (scan_idx_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			running_q    <= '0;
			diff_q       <= '0;
			count_q      <= '0;
			position_q   <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			ovf_q        <= 1'b0;
			active_q     <= 1'b0;
			last_q       <= 1'b0;
			present_q    <= 1'b0;
			scan_idx_q   <= '0;
			valid_s1     <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (target_sum_we) begin
				target_q <= target_sum;
			end
			valid_s1 <= cmd.scan;
			done_q   <= cmd.finish && last_q;

			if (cmd.take) begin
				last_q   <= last;
				active_q <= room;
				if (room) begin
					running_q <= sum_next;
				end else begin
					ovf_q <= 1'b1;
				end
			end

			if (cmd.check) begin
				diff_q     <= running_q - target_q;
				present_q  <= 1'b0;
				scan_idx_q <= '0;
				// whole prefix reaches the target
				if (running_q == target_q) begin
					best_len_q   <= position_q + CNT_W'(1);
					best_start_q <= '0;
					best_end_q   <= position_q[IDX_W-1:0];
				end
			end

			if (cmd.scan) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end

			// strictly longer only, so earlier entries win ties
			if (hit_diff && (cand_len > best_len_q)) begin
				best_len_q   <= cand_len;
				best_start_q <= rd_pos + IDX_W'(1);
				best_end_q   <= position_q[IDX_W-1:0];
			end
			if (hit_same) begin
				present_q <= 1'b1;
			end

			if (cmd.finish) begin
				if (last_q) begin
					running_q    <= '0;
					count_q      <= '0;
					position_q   <= '0;
					best_len_q   <= '0;
					best_start_q <= '0;
					best_end_q   <= '0;
					ovf_q        <= 1'b0;
				end else if (active_q) begin
					if (wr_en) begin
						count_q <= count_q + CNT_W'(1);
					end
					position_q <= position_q + CNT_W'(1);
				end
			end
		end
	end

	// result payload, loaded on the finish of a last element
	always_ff @(posedge clk) begin
		if (cmd.finish && last_q) begin
			best_length <= LEN_W'(best_len_q);
			found       <= (best_len_q != '0);
			start_pos   <= (best_len_q != '0) ? POS_W'(best_start_q) : '0;
			end_pos     <= (best_len_q != '0) ? POS_W'(best_end_q) : '0;
			overflow    <= ovf_q;
		end
	end

	assign done            = done_q;
	assign sts.active      = active_q;
	assign sts.table_empty = (count_q == '0);
	assign sts.scan_end    = (CNT_W'(scan_idx_q) == (count_q - CNT_W'(1)));

`ifndef SYNTHESIS
	a_count_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= position_q)
		else $error("table holds more entries than elements taken");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		position_q <= CNT_W'(DEPTH))
		else $error("position beyond table depth");
	a_best_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		best_len_q <= position_q + CNT_W'(1))
		else $error("best length exceeds elements seen");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.finish && last_q))
		else $error("result strobe without finish of last element");
`endif

endmodule
`default_nettype wire

>>> sv/longest_subarray_with_sum.sv
// top level: longest contiguous subarray reaching a target sum
`default_nettype none
// Usage:
//   target_sum is written with target_sum_we while the block is idle; it
//   survives across arrays and resets to 0.
//   An element transfer happens at a clock edge with start high and busy low;
//   last marks the final element of an array.
//   Each element runs a prefix check and then scans the stored distinct prefix
//   sums one per cycle through the table ram read port, then passes a drain
//   state and a finish state; when the table is empty or the element is
//   beyond the table depth it goes from the check straight to finish. Busy
//   stays high over all these states. While an element is still taken at
//   most DEPTH - 1 prefixes are stored, and no new element is taken until
//   busy falls.
//   After the finish cycle of a last element, done is high for exactly one
//   cycle with best_length, found, start_pos, end_pos and overflow; the
//   result ports hold until the next result. The receiver cannot stall:
//   every done pulse is one result transfer. Array state clears at finish.
//   Reset (arst_n low) clears all array state and target_sum; the table
//   needs no clearing pass, only entries already written are read.
module longest_subarray_with_sum (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               target_sum_we,
	input  wire logic signed [lss_pkg::SUM_W-1:0]   target_sum,
	input  wire logic                               start,
	input  wire logic signed [lss_pkg::ELEM_W-1:0]  element,
	input  wire logic                               last,
	output logic                                    busy,
	output logic                                    done,
	output logic             [lss_pkg::LEN_W-1:0]   best_length,
	output logic                                    found,
	output logic             [lss_pkg::POS_W-1:0]   start_pos,
	output logic             [lss_pkg::POS_W-1:0]   end_pos,
	output logic                                    overflow
);
	import lss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lss_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.target_sum_we (target_sum_we),
		.target_sum    (target_sum),
		.element       (element),
		.last          (last),
		.cmd           (cmd),
		.sts           (sts),
		.done          (done),
		.best_length   (best_length),
		.found         (found),
		.start_pos     (start_pos),
		.end_pos       (end_pos),
		.overflow      (overflow)
	);

endmodule
`default_nettype wire
